FILE: rtl/core/mfau_pkg.sv
// shared types and constants for the motor feedback angle unwrap block
// no dependencies
package mfau_pkg;

  localparam int CountW    = 13;
  localparam int SpeedW    = 16;
  localparam int CurrentW  = 16;
  localparam int TempW     = 8;
  localparam int ScaleW    = 24;
  localparam int AngleW    = 25;
  localparam int SpeedOutW = 17;
  localparam int AmpsW     = 17;
  localparam int InDataW   = 56;
  localparam int OutDataW  = 72;
  localparam int OutPadW   = OutDataW - (AngleW + SpeedOutW + AmpsW + TempW);
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 25;

  // register indexes
  localparam logic [CfgIdxW-1:0] CFG_DEGREE_SCALE     = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_INVERT_DIRECTION = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_INITIAL_ANGLE    = 2'd2;

  // register reset values
  localparam logic [ScaleW-1:0]        DEGREE_SCALE_RST  = 24'd737370;
  localparam logic                     INVERT_RST        = 1'b0;
  localparam logic signed [AngleW-1:0] INITIAL_ANGLE_RST = 25'sd0;

  // encoder turn handling
  localparam logic signed [13:0] COUNTS_PER_TURN = 14'sd8191;
  localparam logic signed [13:0] HALF_TURN       = 14'sd4096;
  localparam logic signed [13:0] NEG_HALF_TURN   = -14'sd4096;

  // degree limits in q16
  localparam logic signed [30:0] DEG180_Q16     = 31'sd11796480;
  localparam logic signed [30:0] NEG_DEG180_Q16 = -31'sd11796480;
  localparam logic signed [30:0] DEG360_Q16     = 31'sd23592960;

  typedef struct packed {
    logic [ScaleW-1:0]        degree_scale;
    logic                     invert_direction;
    logic signed [AngleW-1:0] initial_angle;
  } cfg_t;

  typedef struct packed {
    logic [CountW-1:0]          encoder_count;
    logic signed [SpeedW-1:0]   speed_raw;
    logic signed [CurrentW-1:0] current_raw;
    logic [TempW-1:0]           temperature_raw;
  } frame_t;

  typedef struct packed {
    logic [CountW-1:0]        previous_count;
    logic                     first_frame_pending;
    logic signed [AngleW-1:0] angle_accumulator;
  } track_t;

  typedef struct packed {
    logic signed [AngleW-1:0]    angle_deg_q16;
    logic signed [SpeedOutW-1:0] speed_out;
    logic signed [AmpsW-1:0]     current_amps_q10;
    logic [TempW-1:0]            temperature_out;
  } result_t;

endpackage

FILE: rtl/core/mfau_datapath.sv
// per-frame arithmetic: count unwrap, scaling, accumulate and wrap, speed and current
// depends on mfau_pkg
module mfau_datapath (
  input  mfau_pkg::cfg_t    cfg,
  input  mfau_pkg::track_t  trk,
  input  mfau_pkg::frame_t  frm,
  output mfau_pkg::result_t res
);
  import mfau_pkg::*;

  logic signed [13:0]          d_raw;
  logic signed [13:0]          d_fold;
  logic signed [12:0]          d_adj;
  logic signed [37:0]          prod;
  logic signed [29:0]          step;
  logic signed [29:0]          step_dir;
  logic signed [29:0]          step_eff;
  logic signed [AngleW-1:0]    base;
  logic signed [30:0]          sum;
  logic signed [30:0]          sum_hi;
  logic signed [30:0]          sum_wrap;
  logic signed [SpeedOutW-1:0] speed_ext;
  logic signed [18:0]          cur5;
  logic signed [AmpsW-1:0]     amps;

  always_comb begin
    d_raw = $signed({1'b0, frm.encoder_count}) - $signed({1'b0, trk.previous_count});
    if (d_raw >= HALF_TURN) begin
      d_fold = d_raw - COUNTS_PER_TURN;
    end else if (d_raw <= NEG_HALF_TURN) begin
      d_fold = d_raw + COUNTS_PER_TURN;
    end else begin
      d_fold = d_raw;
    end
    d_adj = d_fold[12:0];

    // q24 product, arithmetic shift gives floor into q16
    prod     = $signed(d_adj) * $signed({1'b0, cfg.degree_scale});
    step     = prod[37:8];
    step_dir = cfg.invert_direction ? -step : step;
    step_eff = trk.first_frame_pending ? 30'sd0 : step_dir;
    base     = trk.first_frame_pending ? cfg.initial_angle : trk.angle_accumulator;

    sum = 31'(base) + 31'(step_eff);
    if (sum > DEG180_Q16) begin
      sum_hi = sum - DEG360_Q16;
    end else begin
      sum_hi = sum;
    end
    if (sum_hi < NEG_DEG180_Q16) begin
      sum_wrap = sum_hi + DEG360_Q16;
    end else begin
      sum_wrap = sum_hi;
    end

    speed_ext = 17'(frm.speed_raw);
    cur5      = 19'(frm.current_raw) * 19'sd5;
    amps      = cur5[18:2];

    res.angle_deg_q16    = sum_wrap[AngleW-1:0];
    res.speed_out        = cfg.invert_direction ? -speed_ext : speed_ext;
    res.current_amps_q10 = cfg.invert_direction ? -amps : amps;
    res.temperature_out  = frm.temperature_raw;
  end

endmodule

FILE: rtl/core/motor_feedback_angle_unwrap.sv
// top level of the motor feedback angle unwrap block
// depends on mfau_pkg and mfau_datapath
// an accepted input word passes the stage register, then the output register, to out_tvalid
// throughput: one word per cycle while out_tready stays high, the accumulator loop closes through one
// 13x25 multiply and one add and wrap compare between stage and output registers
// reset (rst_n low, synchronous): both stages empty, registers back to their
// reset values, the first frame after reset loads the accumulator from initial_angle
module motor_feedback_angle_unwrap (
  input  logic                             clk,
  input  logic                             rst_n,
  // frame input
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // encoder_count[12:0], speed_raw[28:13], current_raw[44:29], temperature_raw[52:45]
  input  logic [mfau_pkg::InDataW-1:0]     in_tdata,
  // result output
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // angle_deg_q16[24:0], speed_out[41:25], current_amps_q10[58:42], temperature_out[66:59]
  output logic [mfau_pkg::OutDataW-1:0]    out_tdata,
  // register write channel
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [mfau_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [mfau_pkg::CfgDataW-1:0]    cfg_data
);
  import mfau_pkg::*;

  // configuration registers
  cfg_t    cfg_r;

  // input stage
  logic    stg_valid_r, stg_valid_nxt;
  frame_t  stg_frame_r;

  // output stage
  logic    out_valid_r, out_valid_nxt;
  result_t out_res_r;

  // unwrap tracking state
  track_t  trk_r, trk_nxt;

  result_t calc_res;
  logic    advance;
  logic    in_fire;

  // stage moves on whenever the output register is empty or being drained,
  // so a new word is taken even while a finished result waits
  assign advance   = stg_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !stg_valid_r || advance;
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  mfau_datapath u_datapath (
    .cfg (cfg_r),
    .trk (trk_r),
    .frm (stg_frame_r),
    .res (calc_res)
  );

  always_comb begin
    stg_valid_nxt = stg_valid_r;
    if (in_tready) begin
      stg_valid_nxt = in_tvalid;
    end

    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end

    // state only moves when the word leaves the stage
    trk_nxt = trk_r;
    if (advance) begin
      trk_nxt.previous_count      = stg_frame_r.encoder_count;
      trk_nxt.first_frame_pending = 1'b0;
      trk_nxt.angle_accumulator   = calc_res.angle_deg_q16;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r                 <= 1'b0;
      out_valid_r                 <= 1'b0;
      trk_r.previous_count        <= '0;
      trk_r.first_frame_pending   <= 1'b1;
      trk_r.angle_accumulator     <= '0;
    end else begin
      stg_valid_r <= stg_valid_nxt;
      out_valid_r <= out_valid_nxt;
      trk_r       <= trk_nxt;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire) begin
      stg_frame_r.encoder_count   <= in_tdata[12:0];
      stg_frame_r.speed_raw       <= in_tdata[28:13];
      stg_frame_r.current_raw     <= in_tdata[44:29];
      stg_frame_r.temperature_raw <= in_tdata[52:45];
    end
    if (advance) begin
      out_res_r <= calc_res;
    end
  end

  // register writes, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.degree_scale     <= DEGREE_SCALE_RST;
      cfg_r.invert_direction <= INVERT_RST;
      cfg_r.initial_angle    <= INITIAL_ANGLE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DEGREE_SCALE:     cfg_r.degree_scale     <= cfg_data[ScaleW-1:0];
        CFG_INVERT_DIRECTION: cfg_r.invert_direction <= cfg_data[0];
        CFG_INITIAL_ANGLE:    cfg_r.initial_angle    <= cfg_data[AngleW-1:0];
        default: ;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{OutPadW{1'b0}},
                       out_res_r.temperature_out,
                       out_res_r.current_amps_q10,
                       out_res_r.speed_out,
                       out_res_r.angle_deg_q16};

endmodule

FILE: rtl/core/mfau_checker.sv
// port-level checks for the motor feedback angle unwrap block, with its bind
// depends on mfau_pkg and motor_feedback_angle_unwrap
module mfau_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tready,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [mfau_pkg::OutDataW-1:0] out_tdata,
  input logic                          cfg_ready
);
  import mfau_pkg::*;

  // a held result word stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  // both stages full is the only reason to refuse input
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input refused with output free");

  // reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // register port never stalls, padding stays zero
  a_cfg_pad: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready && (!out_tvalid || out_tdata[OutDataW-1:OutDataW-OutPadW] == '0))
    else $error("register port stalled or padding set");

endmodule

bind motor_feedback_angle_unwrap mfau_checker u_mfau_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .cfg_ready  (cfg_ready)
);

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// self-checking bench for motor_feedback_angle_unwrap: a directed table, then random frames
// over several register settings, every result word checked against a typed table row or a decoder model kept here
// depends on mfau_pkg and the rtl of motor_feedback_angle_unwrap
module tb_top;
  import mfau_pkg::*;

  // tdata layout, lowest field first
  localparam int InUsedW  = CountW + SpeedW + CurrentW + TempW;
  localparam int SpeedLsb = AngleW;
  localparam int AmpsLsb  = SpeedLsb + SpeedOutW;
  localparam int TempLsb  = AmpsLsb + AmpsW;

  // index 3 has no register behind it, writes there must change nothing
  localparam logic [CfgIdxW-1:0] CFG_SPARE = 2'd3;

  localparam int RandomPhases   = 8;
  localparam int FramesPerPhase = 180;
  localparam int SettleCycles   = 4;   // stage and output registers plus margin
  localparam int WatchdogLimit  = 2000;

  // start angle far below -180 degrees, pulled back by one wrap on the first frame
  localparam logic signed [AngleW-1:0] FAR_START_ANGLE = 25'sh1000000;
  localparam longint FarStartWrapped = 6815744;
  localparam logic signed [AngleW-1:0] PLUS_180 = 25'sd11796480;

  typedef struct {
    frame_t  frame;
    bit      typed;   // expectation written into the table by hand
    result_t want;
  } stim_row_t;

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [InDataW-1:0]    in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OutDataW-1:0]   out_tdata;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CfgIdxW-1:0]    cfg_index  = '0;
  logic [CfgDataW-1:0]   cfg_data   = '0;

  // register mirror
  logic [ScaleW-1:0]        scale_q24       = DEGREE_SCALE_RST;
  logic                     invert_dir      = INVERT_RST;
  logic signed [AngleW-1:0] start_angle_q16 = INITIAL_ANGLE_RST;

  // tracking state mirror
  logic [CountW-1:0]        last_count     = '0;
  logic                     awaiting_first = 1'b1;
  logic signed [AngleW-1:0] angle_acc      = '0;

  result_t   decoded_results[$];   // results still owed by the block, oldest first
  stim_row_t directed_rows[$];

  bit quiet = 1'b0;                // no idling on either side while set
  int mismatch_count = 0;
  int frames_sent    = 0;
  int results_seen   = 0;
  int reg_writes     = 0;
  int idle_cycles    = 0;

  motor_feedback_angle_unwrap u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // decode one frame the way the block should, and advance the mirrored state
  function automatic result_t decode_frame(input frame_t f);
    longint  d;
    longint  step;
    longint  sum;
    longint  spd;
    longint  amps;
    result_t r;
    step = 0;
    if (awaiting_first) begin
      // first frame after reset: no step, accumulator starts from the register
      awaiting_first = 1'b0;
      angle_acc      = start_angle_q16;
    end else begin
      d = longint'(f.encoder_count) - longint'(last_count);
      // shortest way round the turn
      if (d >= longint'(HALF_TURN)) d = d - longint'(COUNTS_PER_TURN);
      else if (d <= longint'(NEG_HALF_TURN)) d = d + longint'(COUNTS_PER_TURN);
      // q24 product floored to q16
      step = (d * longint'(scale_q24)) >>> 8;
      if (invert_dir) step = -step;
    end
    last_count = f.encoder_count;
    sum = longint'(angle_acc) + step;
    // one wrap only, then the accumulator keeps its low bits
    if (sum > longint'(DEG180_Q16)) sum = sum - longint'(DEG360_Q16);
    if (sum < longint'(NEG_DEG180_Q16)) sum = sum + longint'(DEG360_Q16);
    angle_acc = AngleW'(sum);

    spd  = longint'($signed(f.speed_raw));
    amps = (longint'($signed(f.current_raw)) * 5) >>> 2;   // floor of 5/4
    if (invert_dir) begin
      spd  = -spd;
      amps = -amps;
    end
    r.angle_deg_q16    = angle_acc;
    r.speed_out        = SpeedOutW'(spd);
    r.current_amps_q10 = AmpsW'(amps);
    r.temperature_out  = f.temperature_raw;
    return r;
  endfunction

  function automatic logic [15:0] pick_word16();
    if ($urandom_range(99) < 12) begin
      case ($urandom_range(4))
        0:       return 16'h8000;
        1:       return 16'h7FFF;
        2:       return 16'hFFFF;
        3:       return 16'h0000;
        default: return 16'h0001;
      endcase
    end
    return 16'($urandom);
  endfunction

  task automatic add_row(input int cnt, input int spd, input int cur, input int tmp,
                         input bit typed, input longint e_ang, input longint e_spd,
                         input longint e_amp, input longint e_tmp);
    stim_row_t row;
    row.frame.encoder_count   = CountW'(cnt);
    row.frame.speed_raw       = SpeedW'(spd);
    row.frame.current_raw     = CurrentW'(cur);
    row.frame.temperature_raw = TempW'(tmp);
    row.typed                 = typed;
    row.want.angle_deg_q16    = AngleW'(e_ang);
    row.want.speed_out        = SpeedOutW'(e_spd);
    row.want.current_amps_q10 = AmpsW'(e_amp);
    row.want.temperature_out  = TempW'(e_tmp);
    directed_rows.push_back(row);
  endtask

  // called at a falling edge, returns at the falling edge after the write is taken
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_DEGREE_SCALE:     scale_q24       = val[ScaleW-1:0];
      CFG_INVERT_DIRECTION: invert_dir      = val[0];
      CFG_INITIAL_ANGLE:    start_angle_q16 = val[AngleW-1:0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
  endtask

  // called at a falling edge; in_tvalid stays high into the next word unless a gap is drawn
  task automatic send_frame(input frame_t f, input bit typed, input result_t want);
    result_t r;
    if (!quiet && $urandom_range(99) < 12) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(InDataW-InUsedW){1'b0}}, f.temperature_raw, f.current_raw,
                  f.speed_raw, f.encoder_count};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    // the model always runs so its state follows the block
    r = decode_frame(f);
    decoded_results.push_back(typed ? want : r);
    frames_sent++;
    @(negedge clk);
  endtask

  // stop sending and let every owed result come out before touching registers
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (decoded_results.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic report_field(input string field, input longint want, input longint got);
    $display("%0t: mismatch on %s, expected %0d, got %0d", $time, field, want, got);
    mismatch_count++;
  endtask

  // receiver stalls at random, except during the quiet stretch
  always @(negedge clk) begin
    out_tready <= quiet || ($urandom_range(99) >= 11);
  end

  // result checker: each accepted word against the oldest expectation
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.angle_deg_q16    = out_tdata[SpeedLsb-1:0];
      got.speed_out        = out_tdata[AmpsLsb-1:SpeedLsb];
      got.current_amps_q10 = out_tdata[TempLsb-1:AmpsLsb];
      got.temperature_out  = out_tdata[TempLsb+TempW-1:TempLsb];
      results_seen++;
      if (decoded_results.size() == 0) begin
        $display("%0t: result word with nothing expected, angle %0d", $time,
                 got.angle_deg_q16);
        mismatch_count++;
      end else begin
        want = decoded_results.pop_front();
        if (got.angle_deg_q16 !== want.angle_deg_q16)
          report_field("angle_deg_q16", want.angle_deg_q16, got.angle_deg_q16);
        if (got.speed_out !== want.speed_out)
          report_field("speed_out", want.speed_out, got.speed_out);
        if (got.current_amps_q10 !== want.current_amps_q10)
          report_field("current_amps_q10", want.current_amps_q10, got.current_amps_q10);
        if (got.temperature_out !== want.temperature_out)
          report_field("temperature_out", want.temperature_out, got.temperature_out);
      end
    end
  end

  // watchdog on cycles where no channel moves a word
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("%0t: no handshake for %0d cycles, %0d results outstanding", $time,
               idle_cycles, decoded_results.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    frame_t            f;
    result_t           no_want;
    logic [CountW-1:0] cnt;
    logic [ScaleW-1:0] sc;
    logic              iv;
    logic [AngleW-1:0] ia;
    int                delta;

    no_want = '0;

    // directed table; the first five keep the encoder still so the angle stays at the
    // wrapped start value and every field can be written down directly
    add_row(100,      0,      0,   0, 1, FarStartWrapped,      0,      0,   0);
    add_row(100, -32768, -32768, 255, 1, FarStartWrapped, -32768, -40960, 255);
    add_row(100,  32767,  32767, 128, 1, FarStartWrapped,  32767,  40958, 128);
    add_row(100,     -1,     -1,   1, 1, FarStartWrapped,     -1,     -2,   1);
    add_row(100,      1,      1, 127, 1, FarStartWrapped,      1,      1, 127);
    // half-turn boundaries, the out-of-range count and its wrap back to zero
    add_row(4195,  1234,  -4321,  17, 0, 0, 0, 0, 0);
    add_row(99,   -1234,   4321,  34, 0, 0, 0, 0, 0);
    add_row(8191, 21845, -21846,  85, 0, 0, 0, 0, 0);
    add_row(0,   -21846,  21845, 170, 0, 0, 0, 0, 0);
    add_row(4096,   255,   -256, 240, 0, 0, 0, 0, 0);
    add_row(0,     -256,    255,  15, 0, 0, 0, 0, 0);
    add_row(4095,  4096,  -4097,  60, 0, 0, 0, 0, 0);
    add_row(1,    -4097,   4096, 195, 0, 0, 0, 0, 0);
    add_row(8190,  3000,   -3,     8, 0, 0, 0, 0, 0);
    add_row(8191,    -3,   3000, 247, 0, 0, 0, 0, 0);
    add_row(0,      77,     -77,  99, 0, 0, 0, 0, 0);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset values for scale and direction, start angle far out of range
    write_reg(CFG_INITIAL_ANGLE, FAR_START_ANGLE);
    cfg_valid <= 1'b0;

    foreach (directed_rows[i])
      send_frame(directed_rows[i].frame, directed_rows[i].typed, directed_rows[i].want);
    cnt = directed_rows[directed_rows.size()-1].frame.encoder_count;
    wait_drained();

    for (int ph = 0; ph < RandomPhases; ph++) begin
      ia = AngleW'($urandom);
      case (ph)
        0:       begin sc = DEGREE_SCALE_RST; iv = 1'b1; ia = '0;        end
        1:       begin sc = 24'd1;            iv = 1'b0; ia = PLUS_180;  end
        2:       begin sc = 24'hFFFFFF;       iv = 1'b1; ia = -PLUS_180; end
        3:       begin sc = 24'hFFFFFF;       iv = 1'b0;                 end
        5:       begin sc = 24'd1;            iv = 1'b1;                 end
        6:       begin sc = 24'h800000;       iv = 1'b0;                 end
        default: begin
          sc = ScaleW'($urandom_range(1, 24'hFFFFFF));
          iv = 1'(($urandom_range(1)));
        end
      endcase
      write_reg(CFG_DEGREE_SCALE, {1'b0, sc});
      write_reg(CFG_INVERT_DIRECTION, CfgDataW'(iv));
      // start angle is only read on the first frame, so these writes must do nothing
      write_reg(CFG_INITIAL_ANGLE, ia);
      if (ph == 2) write_reg(CFG_SPARE, CfgDataW'($urandom));
      cfg_valid <= 1'b0;

      // one phase runs flat out on both sides
      quiet = (ph == 3);

      for (int n = 0; n < FramesPerPhase; n++) begin
        // mostly a turning shaft, some half-turn jumps, the ends of the count and noise
        case ($urandom_range(99)) inside
          [0:59]: cnt = cnt + CountW'($urandom_range(80)) - CountW'(40);
          [60:74]: begin
            delta = 4095 + $urandom_range(2);
            if ($urandom_range(1)) cnt = cnt + CountW'(delta);
            else cnt = cnt - CountW'(delta);
          end
          [75:84]: cnt = $urandom_range(1) ? CountW'(8191) : CountW'(0);
          default: cnt = CountW'($urandom);
        endcase
        f.encoder_count   = cnt;
        f.speed_raw       = pick_word16();
        f.current_raw     = pick_word16();
        f.temperature_raw = ($urandom_range(9) == 0) ?
                            ($urandom_range(1) ? 8'hFF : 8'h00) : TempW'($urandom);
        send_frame(f, 1'b0, no_want);
        // sender holds back mid-phase until the block has emptied
        if (ph == 4 && n == FramesPerPhase / 2) wait_drained();
      end
      quiet = 1'b0;
      wait_drained();
    end

    $display("run covered %0d frames (%0d from the table) and %0d result words", frames_sent,
             directed_rows.size(), results_seen);
    $display("over %0d register writes across %0d settings, %0d mismatches", reg_writes,
             RandomPhases + 1, mismatch_count);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
